>>> rtl/rrts_pkg.sv
// Shared types and constants for the rectangle / right-triangle resolver.
// Depends on nothing; every other file imports it.
`timescale 1ns / 1ps
`default_nettype none

package rrts_pkg;

    // One collision query, all Q16.16 style fixed point
    typedef struct packed {
        logic signed [31:0] rect_x;
        logic signed [31:0] rect_y;
        logic        [30:0] rect_w;
        logic        [30:0] rect_h;
        logic signed [31:0] tri_x;
        logic signed [31:0] tri_y;
        logic signed [31:0] tri_bx;
        logic signed [31:0] tri_by;
    } query_t;

    // Resolution vector
    typedef struct packed {
        logic signed [31:0] push_x;
        logic signed [31:0] push_y;
    } result_t;

    // Separating axes in test order
    typedef enum logic [1:0] {
        AXIS_Y,
        AXIS_X,
        AXIS_N
    } axis_t;

    // Width of a corner coordinate after adding a size or a bound
    localparam int CW = 33;
    typedef logic signed [CW-1:0] coord_t;

    // Result bits of the square root, one per pipeline stage
    localparam int SQRT_STEPS = 32;

    // Stages before the root (input, squares, sum) and after the divide
    localparam int FRONT_STAGES = 3;
    localparam int GEO_STAGES   = 11;

    // Overlap at or above this (in whole units) never qualifies
    localparam logic [63:0] OVERLAP_START = 64'd10000000;

    // Saturation limits for the push magnitude
    localparam logic [63:0] NEG_LIMIT = 64'h0000_0000_8000_0000;
    localparam logic [63:0] POS_LIMIT = 64'h0000_0000_7FFF_FFFF;

    // Magnitude of a 32-bit signed value; the most negative value maps to 2^31
    function automatic logic [31:0] mag32(input logic signed [31:0] v);
        return v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic coord_t cmin(input coord_t a, input coord_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic coord_t cmax(input coord_t a, input coord_t b);
        return (a > b) ? a : b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/rect_right_triangle_sat_resolve.sv
// Top level of the rectangle / right-triangle separating-axis resolver.
// Depends on rrts_pkg for the query and result types and shared constants.
`timescale 1ns / 1ps
`default_nettype none

// Resolves an axis-aligned rectangle against a right triangle by the
// separating axis test on the y axis, the x axis and the hypotenuse normal,
// and returns the minimum push vector in saturated signed fixed point with
// FRAC_BITS fraction bits. The block is a fixed-latency pipeline: one query
// is taken per clock whenever busy is low (busy is high only in reset and
// until the run register sets after it), and its result shows on result with
// done high once it has passed the front registers, the square root, the
// divide and the geometry stages. The depth comes mostly from the 32-stage
// square root of the bound length and the FRAC_BITS + 1 stage restoring divide
// that normalizes the hypotenuse normal. Results are presented for one cycle
// only; the receiver must take every transfer as it comes.
module rect_right_triangle_sat_resolve
    import rrts_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    start,
    output logic         busy,
    input  wire query_t  query,
    output logic         done,
    output result_t      result
);

    localparam int QW = FRAC_BITS + 1;      // normal magnitude bits
    localparam int NW = FRAC_BITS + 2;      // signed normal component
    localparam int PW = CW + NW;            // coordinate times normal
    localparam int DW = PW + 1;             // dot product of two terms
    localparam int OW = DW + 1;             // overlap at scale 2^(2F)
    localparam int FW = FRAC_BITS + 24;     // overlap truncated to Q.F

    typedef struct packed {
        logic signed [NW-1:0] nx;
        logic signed [NW-1:0] ny;
        logic                 neg0;
        logic                 neg1;
    } side_t;

    function automatic logic qualifies(input logic [OW-1:0] ov);
        return 64'(ov >> (2 * FRAC_BITS)) < OVERLAP_START;
    endfunction

    function automatic logic signed [DW-1:0] dmin(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [DW-1:0] dmax(input logic signed [DW-1:0] a,
                                                  input logic signed [DW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [31:0] sat_push(input logic neg,
                                                    input logic [FW-1:0] m);
        logic signed [31:0] v;
        v = '0;
        if (m != '0) begin
            if (neg) begin
                v = (64'(m) > NEG_LIMIT) ? 32'sh8000_0000 : -$signed(m[31:0]);
            end
            else begin
                v = (64'(m) > POS_LIMIT) ? 32'sh7FFF_FFFF : $signed(m[31:0]);
            end
        end
        return v;
    endfunction

    // ------------------------------------------------------------------
    // Input register, squares and sum
    // ------------------------------------------------------------------
    logic         run_reg;
    logic         s0_v_reg;
    query_t       s0_q_reg;
    logic         s1_v_reg;
    query_t       s1_q_reg;
    logic [63:0]  s1_bx2_reg;
    logic [63:0]  s1_by2_reg;
    logic [31:0]  s0_bxm;
    logic [31:0]  s0_bym;
    logic [63:0]  s1_bx2_next;
    logic [63:0]  s1_by2_next;

    assign busy   = ~run_reg;
    assign s0_bxm = mag32(s0_q_reg.tri_bx);
    assign s0_bym = mag32(s0_q_reg.tri_by);
    assign s1_bx2_next = 64'(s0_bxm) * 64'(s0_bxm);
    assign s1_by2_next = 64'(s0_bym) * 64'(s0_bym);

    // Square root pipeline registers, stage 0 holds the radicand
    logic         sq_v_reg    [SQRT_STEPS+1];
    query_t       sq_q_reg    [SQRT_STEPS+1];
    logic [63:0]  sq_rad_reg  [SQRT_STEPS+1];
    logic [34:0]  sq_rem_reg  [SQRT_STEPS+1];
    logic [31:0]  sq_root_reg [SQRT_STEPS+1];

    // Hold front-end control
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            run_reg     <= 1'b0;
            s0_v_reg    <= 1'b0;
            s1_v_reg    <= 1'b0;
            sq_v_reg[0] <= 1'b0;
        end
        else begin
            run_reg     <= 1'b1;
            s0_v_reg    <= start & ~busy;
            s1_v_reg    <= s0_v_reg;
            sq_v_reg[0] <= s1_v_reg;
        end
    end

    // Advance front-end payload
    always_ff @(posedge clk) begin
        s0_q_reg       <= query;
        s1_q_reg       <= s0_q_reg;
        s1_bx2_reg     <= s1_bx2_next;
        s1_by2_reg     <= s1_by2_next;
        sq_q_reg[0]    <= s1_q_reg;
        sq_rad_reg[0]  <= s1_bx2_reg + s1_by2_reg;
        sq_rem_reg[0]  <= '0;
        sq_root_reg[0] <= '0;
    end

    // ------------------------------------------------------------------
    // Digit-by-digit square root, one result bit per stage
    // ------------------------------------------------------------------
    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        logic [34:0] rem_sh;
        logic [34:0] trial;
        logic        take;
        logic [34:0] rem_next;
        logic [31:0] root_next;

        always_comb begin
            rem_sh    = {sq_rem_reg[k][32:0], sq_rad_reg[k][63:62]};
            trial     = {1'b0, sq_root_reg[k], 2'b01};
            take      = (rem_sh >= trial);
            rem_next  = take ? (rem_sh - trial) : rem_sh;
            root_next = {sq_root_reg[k][30:0], take};
        end

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                sq_v_reg[k+1] <= 1'b0;
            end
            else begin
                sq_v_reg[k+1] <= sq_v_reg[k];
            end
        end

        always_ff @(posedge clk) begin
            sq_q_reg[k+1]    <= sq_q_reg[k];
            sq_rad_reg[k+1]  <= {sq_rad_reg[k][61:0], 2'b00};
            sq_rem_reg[k+1]  <= rem_next;
            sq_root_reg[k+1] <= root_next;
        end
    end

    // ------------------------------------------------------------------
    // Restoring divide of |by| and |bx| by the root, one quotient bit a stage
    // ------------------------------------------------------------------
    logic          dv_v_reg    [QW];
    query_t        dv_q_reg    [QW];
    logic [31:0]   dv_r_reg    [QW];
    logic [31:0]   dv_remx_reg [QW];
    logic [31:0]   dv_remy_reg [QW];
    logic [QW-1:0] dv_quox_reg [QW];
    logic [QW-1:0] dv_quoy_reg [QW];

    for (genvar j = 0; j < QW; j++) begin : g_div
        logic          src_v;
        query_t        src_q;
        logic [31:0]   src_r;
        logic [32:0]   shx;
        logic [32:0]   shy;
        logic [QW-1:0] src_qx;
        logic [QW-1:0] src_qy;
        logic          bit_x;
        logic          bit_y;
        logic [32:0]   difx;
        logic [32:0]   dify;

        if (j == 0) begin : g_first
            assign src_v  = sq_v_reg[SQRT_STEPS];
            assign src_q  = sq_q_reg[SQRT_STEPS];
            assign src_r  = sq_root_reg[SQRT_STEPS];
            assign shx    = {1'b0, mag32(sq_q_reg[SQRT_STEPS].tri_by)};
            assign shy    = {1'b0, mag32(sq_q_reg[SQRT_STEPS].tri_bx)};
            assign src_qx = '0;
            assign src_qy = '0;
        end
        else begin : g_rest
            assign src_v  = dv_v_reg[j-1];
            assign src_q  = dv_q_reg[j-1];
            assign src_r  = dv_r_reg[j-1];
            assign shx    = {dv_remx_reg[j-1], 1'b0};
            assign shy    = {dv_remy_reg[j-1], 1'b0};
            assign src_qx = dv_quox_reg[j-1];
            assign src_qy = dv_quoy_reg[j-1];
        end

        assign difx  = shx - {1'b0, src_r};
        assign dify  = shy - {1'b0, src_r};
        assign bit_x = (shx >= {1'b0, src_r});
        assign bit_y = (shy >= {1'b0, src_r});

        always_ff @(posedge clk or negedge rst_n) begin
            if (!rst_n) begin
                dv_v_reg[j] <= 1'b0;
            end
            else begin
                dv_v_reg[j] <= src_v;
            end
        end

        always_ff @(posedge clk) begin
            dv_q_reg[j]    <= src_q;
            dv_r_reg[j]    <= src_r;
            dv_remx_reg[j] <= bit_x ? difx[31:0] : shx[31:0];
            dv_remy_reg[j] <= bit_y ? dify[31:0] : shy[31:0];
            dv_quox_reg[j] <= {src_qx[QW-2:0], bit_x};
            dv_quoy_reg[j] <= {src_qy[QW-2:0], bit_y};
        end
    end

    // ------------------------------------------------------------------
    // G1: signed normal and corner coordinates
    // ------------------------------------------------------------------
    query_t               dq;
    logic signed [NW-1:0] qx_s;
    logic signed [NW-1:0] qy_s;
    logic                 r_zero;
    side_t                g1_side_next;

    assign dq     = dv_q_reg[QW-1];
    assign qx_s   = $signed({1'b0, dv_quox_reg[QW-1]});
    assign qy_s   = $signed({1'b0, dv_quoy_reg[QW-1]});
    assign r_zero = (dv_r_reg[QW-1] == '0);

    always_comb begin
        g1_side_next.nx   = r_zero ? '0 : (dq.tri_by[31] ? -qx_s : qx_s);
        g1_side_next.ny   = r_zero ? '0 : (dq.tri_bx[31] ? qy_s : -qy_s);
        g1_side_next.neg0 = (CW'(dq.rect_y) - CW'(dq.tri_y)) < 0;
        g1_side_next.neg1 = (CW'(dq.rect_x) - CW'(dq.tri_x)) < 0;
    end

    logic   g1_v_reg;
    side_t  g1_side_reg;
    coord_t g1_rx0_reg, g1_rx1_reg, g1_ry0_reg, g1_ry1_reg;
    coord_t g1_tx0_reg, g1_tx1_reg, g1_ty0_reg, g1_ty1_reg;
    coord_t g1_dx_reg, g1_dy_reg;

    // ------------------------------------------------------------------
    // G2: normal products; tri extents on y and x
    // ------------------------------------------------------------------
    logic                 g2_v_reg;
    side_t                g2_side_reg;
    logic signed [PW-1:0] g2_rx0_reg, g2_rx1_reg, g2_ry0_reg, g2_ry1_reg;
    logic signed [PW-1:0] g2_tx0_reg, g2_tx1_reg, g2_ty0_reg, g2_ty1_reg;
    logic signed [PW-1:0] g2_dx_reg, g2_dy_reg;
    coord_t               g2_ylo_reg, g2_yhi_reg, g2_xlo_reg, g2_xhi_reg;
    coord_t               g2_ry0c_reg, g2_ry1c_reg, g2_rx0c_reg, g2_rx1c_reg;

    // ------------------------------------------------------------------
    // G3: dot sums; axis y / x interval ends
    // ------------------------------------------------------------------
    logic                 g3_v_reg;
    side_t                g3_side_reg;
    logic signed [DW-1:0] g3_r0_reg, g3_r1_reg, g3_r2_reg, g3_r3_reg;
    logic signed [DW-1:0] g3_t0_reg, g3_t1_reg, g3_t2_reg;
    logic                 g3_neg2_reg;
    coord_t               g3_hi0_reg, g3_lo0_reg, g3_hi1_reg, g3_lo1_reg;

    // G4: pairwise min/max; axis y / x raw overlap
    logic                 g4_v_reg;
    side_t                g4_side_reg;
    logic signed [DW-1:0] g4_ramin_reg, g4_ramax_reg, g4_rbmin_reg, g4_rbmax_reg;
    logic signed [DW-1:0] g4_tamin_reg, g4_tamax_reg, g4_t2_reg;
    logic                 g4_neg2_reg;
    logic signed [CW:0]   g4_raw0_reg, g4_raw1_reg;

    // G5: full extents; axis y / x overlap clamped and scaled
    logic                 g5_v_reg;
    side_t                g5_side_reg;
    logic signed [DW-1:0] g5_rmin_reg, g5_rmax_reg, g5_tmin_reg, g5_tmax_reg;
    logic                 g5_neg2_reg;
    logic [OW-1:0]        g5_ov0_reg, g5_ov1_reg;

    // G6: interval ends on the normal
    logic                 g6_v_reg;
    side_t                g6_side_reg;
    logic signed [DW-1:0] g6_hi_reg, g6_lo_reg;
    logic                 g6_neg2_reg;
    logic [OW-1:0]        g6_ov0_reg, g6_ov1_reg;

    // G7: overlap on the normal
    logic                 g7_v_reg;
    side_t                g7_side_reg;
    logic [OW-1:0]        g7_ov2_reg;
    logic                 g7_neg2_reg;
    logic [OW-1:0]        g7_ov0_reg, g7_ov1_reg;

    // G8: pick between the y and x axes
    logic                 g8_v_reg;
    side_t                g8_side_reg;
    logic [OW-1:0]        g8_best_reg;
    logic                 g8_have_reg;
    axis_t                g8_axis_reg;
    logic                 g8_neg_reg;
    logic                 g8_zero_reg;
    logic [OW-1:0]        g8_ov2_reg;
    logic                 g8_neg2_reg;

    // G9: bring in the normal axis
    logic                 g9_v_reg;
    side_t                g9_side_reg;
    logic [OW-1:0]        g9_best_reg;
    axis_t                g9_axis_reg;
    logic                 g9_neg_reg;
    logic                 g9_kill_reg;

    // G10: scale the chosen axis by the overlap
    logic                 g10_v_reg;
    logic [FW-1:0]        g10_mx_reg, g10_my_reg;
    logic                 g10_nx_reg, g10_ny_reg;
    logic                 g10_kill_reg;

    // G11: output register
    logic                 done_reg;
    result_t              result_reg;

    // Selection between axis y and axis x
    logic          sel1;
    logic [OW-1:0] g8_best_next;
    logic          g8_have_next;
    axis_t         g8_axis_next;
    logic          g8_neg_next;

    always_comb begin
        sel1         = qualifies(g7_ov0_reg) ? (g7_ov1_reg < g7_ov0_reg)
                                             : qualifies(g7_ov1_reg);
        g8_have_next = qualifies(g7_ov0_reg) | sel1;
        g8_best_next = sel1 ? g7_ov1_reg : g7_ov0_reg;
        g8_axis_next = sel1 ? AXIS_X : AXIS_Y;
        g8_neg_next  = sel1 ? g7_side_reg.neg1 : g7_side_reg.neg0;
    end

    // Selection against the normal axis
    logic          sel2;
    logic [OW-1:0] g9_best_next;
    axis_t         g9_axis_next;
    logic          g9_neg_next;
    logic          g9_kill_next;

    always_comb begin
        sel2         = g8_have_reg ? (g8_ov2_reg < g8_best_reg) : qualifies(g8_ov2_reg);
        g9_best_next = sel2 ? g8_ov2_reg : g8_best_reg;
        g9_axis_next = sel2 ? AXIS_N : g8_axis_reg;
        g9_neg_next  = sel2 ? g8_neg2_reg : g8_neg_reg;
        g9_kill_next = g8_zero_reg | (g8_ov2_reg == '0) | ~(g8_have_reg | sel2);
    end

    // Axis components of the winner
    logic [FW-1:0]           ovf;
    logic [QW-1:0]           magx, magy;
    logic                    sgnx, sgny;
    logic [FW+QW-1:0]        prodx, prody;

    always_comb begin
        ovf  = FW'(g9_best_reg >> FRAC_BITS);
        magx = '0;
        magy = '0;
        sgnx = 1'b0;
        sgny = 1'b0;
        unique case (g9_axis_reg)
            AXIS_Y: magy = QW'(1) << FRAC_BITS;
            AXIS_X: magx = QW'(1) << FRAC_BITS;
            AXIS_N: begin
                magx = QW'(g9_side_reg.nx[NW-1] ? -g9_side_reg.nx : g9_side_reg.nx);
                magy = QW'(g9_side_reg.ny[NW-1] ? -g9_side_reg.ny : g9_side_reg.ny);
                sgnx = g9_side_reg.nx[NW-1];
                sgny = g9_side_reg.ny[NW-1];
            end
            default: begin
                magx = '0;
                magy = '0;
            end
        endcase
        prodx = (FW+QW)'(ovf) * (FW+QW)'(magx);
        prody = (FW+QW)'(ovf) * (FW+QW)'(magy);
    end

    // Hold geometry stage control
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            g1_v_reg  <= 1'b0;
            g2_v_reg  <= 1'b0;
            g3_v_reg  <= 1'b0;
            g4_v_reg  <= 1'b0;
            g5_v_reg  <= 1'b0;
            g6_v_reg  <= 1'b0;
            g7_v_reg  <= 1'b0;
            g8_v_reg  <= 1'b0;
            g9_v_reg  <= 1'b0;
            g10_v_reg <= 1'b0;
            done_reg  <= 1'b0;
        end
        else begin
            g1_v_reg  <= dv_v_reg[QW-1];
            g2_v_reg  <= g1_v_reg;
            g3_v_reg  <= g2_v_reg;
            g4_v_reg  <= g3_v_reg;
            g5_v_reg  <= g4_v_reg;
            g6_v_reg  <= g5_v_reg;
            g7_v_reg  <= g6_v_reg;
            g8_v_reg  <= g7_v_reg;
            g9_v_reg  <= g8_v_reg;
            g10_v_reg <= g9_v_reg;
            done_reg  <= g10_v_reg;
        end
    end

    // Advance geometry payload
    always_ff @(posedge clk) begin
        // G1
        g1_side_reg <= g1_side_next;
        g1_rx0_reg  <= CW'(dq.rect_x);
        g1_rx1_reg  <= CW'(dq.rect_x) + CW'(dq.rect_w);
        g1_ry0_reg  <= CW'(dq.rect_y);
        g1_ry1_reg  <= CW'(dq.rect_y) + CW'(dq.rect_h);
        g1_tx0_reg  <= CW'(dq.tri_x);
        g1_tx1_reg  <= CW'(dq.tri_x) + CW'(dq.tri_bx);
        g1_ty0_reg  <= CW'(dq.tri_y);
        g1_ty1_reg  <= CW'(dq.tri_y) + CW'(dq.tri_by);
        g1_dx_reg   <= CW'(dq.rect_x) - CW'(dq.tri_x);
        g1_dy_reg   <= CW'(dq.rect_y) - CW'(dq.tri_y);

        // G2
        g2_side_reg <= g1_side_reg;
        g2_rx0_reg  <= PW'(g1_rx0_reg) * PW'(g1_side_reg.nx);
        g2_rx1_reg  <= PW'(g1_rx1_reg) * PW'(g1_side_reg.nx);
        g2_ry0_reg  <= PW'(g1_ry0_reg) * PW'(g1_side_reg.ny);
        g2_ry1_reg  <= PW'(g1_ry1_reg) * PW'(g1_side_reg.ny);
        g2_tx0_reg  <= PW'(g1_tx0_reg) * PW'(g1_side_reg.nx);
        g2_tx1_reg  <= PW'(g1_tx1_reg) * PW'(g1_side_reg.nx);
        g2_ty0_reg  <= PW'(g1_ty0_reg) * PW'(g1_side_reg.ny);
        g2_ty1_reg  <= PW'(g1_ty1_reg) * PW'(g1_side_reg.ny);
        g2_dx_reg   <= PW'(g1_dx_reg) * PW'(g1_side_reg.nx);
        g2_dy_reg   <= PW'(g1_dy_reg) * PW'(g1_side_reg.ny);
        g2_ylo_reg  <= cmin(g1_ty0_reg, g1_ty1_reg);
        g2_yhi_reg  <= cmax(g1_ty0_reg, g1_ty1_reg);
        g2_xlo_reg  <= cmin(g1_tx0_reg, g1_tx1_reg);
        g2_xhi_reg  <= cmax(g1_tx0_reg, g1_tx1_reg);
        g2_ry0c_reg <= g1_ry0_reg;
        g2_ry1c_reg <= g1_ry1_reg;
        g2_rx0c_reg <= g1_rx0_reg;
        g2_rx1c_reg <= g1_rx1_reg;

        // G3
        g3_side_reg <= g2_side_reg;
        g3_r0_reg   <= DW'(g2_rx0_reg) + DW'(g2_ry0_reg);
        g3_r1_reg   <= DW'(g2_rx1_reg) + DW'(g2_ry0_reg);
        g3_r2_reg   <= DW'(g2_rx1_reg) + DW'(g2_ry1_reg);
        g3_r3_reg   <= DW'(g2_rx0_reg) + DW'(g2_ry1_reg);
        g3_t0_reg   <= DW'(g2_tx0_reg) + DW'(g2_ty0_reg);
        g3_t1_reg   <= DW'(g2_tx0_reg) + DW'(g2_ty1_reg);
        g3_t2_reg   <= DW'(g2_tx1_reg) + DW'(g2_ty1_reg);
        g3_neg2_reg <= (DW'(g2_dx_reg) + DW'(g2_dy_reg)) < 0;
        g3_hi0_reg  <= cmin(g2_ry1c_reg, g2_yhi_reg);
        g3_lo0_reg  <= cmax(g2_ry0c_reg, g2_ylo_reg);
        g3_hi1_reg  <= cmin(g2_rx1c_reg, g2_xhi_reg);
        g3_lo1_reg  <= cmax(g2_rx0c_reg, g2_xlo_reg);

        // G4
        g4_side_reg  <= g3_side_reg;
        g4_ramin_reg <= dmin(g3_r0_reg, g3_r1_reg);
        g4_ramax_reg <= dmax(g3_r0_reg, g3_r1_reg);
        g4_rbmin_reg <= dmin(g3_r2_reg, g3_r3_reg);
        g4_rbmax_reg <= dmax(g3_r2_reg, g3_r3_reg);
        g4_tamin_reg <= dmin(g3_t0_reg, g3_t1_reg);
        g4_tamax_reg <= dmax(g3_t0_reg, g3_t1_reg);
        g4_t2_reg    <= g3_t2_reg;
        g4_neg2_reg  <= g3_neg2_reg;
        g4_raw0_reg  <= (CW+1)'(g3_hi0_reg) - (CW+1)'(g3_lo0_reg);
        g4_raw1_reg  <= (CW+1)'(g3_hi1_reg) - (CW+1)'(g3_lo1_reg);

        // G5
        g5_side_reg <= g4_side_reg;
        g5_rmin_reg <= dmin(g4_ramin_reg, g4_rbmin_reg);
        g5_rmax_reg <= dmax(g4_ramax_reg, g4_rbmax_reg);
        g5_tmin_reg <= dmin(g4_tamin_reg, g4_t2_reg);
        g5_tmax_reg <= dmax(g4_tamax_reg, g4_t2_reg);
        g5_neg2_reg <= g4_neg2_reg;
        g5_ov0_reg  <= g4_raw0_reg[CW] ? '0
                                       : OW'($unsigned(g4_raw0_reg)) << FRAC_BITS;
        g5_ov1_reg  <= g4_raw1_reg[CW] ? '0
                                       : OW'($unsigned(g4_raw1_reg)) << FRAC_BITS;

        // G6
        g6_side_reg <= g5_side_reg;
        g6_hi_reg   <= dmin(g5_rmax_reg, g5_tmax_reg);
        g6_lo_reg   <= dmax(g5_rmin_reg, g5_tmin_reg);
        g6_neg2_reg <= g5_neg2_reg;
        g6_ov0_reg  <= g5_ov0_reg;
        g6_ov1_reg  <= g5_ov1_reg;

        // G7: clamp a negative overlap to zero
        g7_side_reg <= g6_side_reg;
        g7_ov2_reg  <= (g6_hi_reg < g6_lo_reg) ? '0
                                               : OW'(OW'(g6_hi_reg) - OW'(g6_lo_reg));
        g7_neg2_reg <= g6_neg2_reg;
        g7_ov0_reg  <= g6_ov0_reg;
        g7_ov1_reg  <= g6_ov1_reg;

        // G8
        g8_side_reg <= g7_side_reg;
        g8_best_reg <= g8_best_next;
        g8_have_reg <= g8_have_next;
        g8_axis_reg <= g8_axis_next;
        g8_neg_reg  <= g8_neg_next;
        g8_zero_reg <= (g7_ov0_reg == '0) | (g7_ov1_reg == '0);
        g8_ov2_reg  <= g7_ov2_reg;
        g8_neg2_reg <= g7_neg2_reg;

        // G9
        g9_side_reg <= g8_side_reg;
        g9_best_reg <= g9_best_next;
        g9_axis_reg <= g9_axis_next;
        g9_neg_reg  <= g9_neg_next;
        g9_kill_reg <= g9_kill_next;

        // G10
        g10_mx_reg   <= FW'(prodx >> FRAC_BITS);
        g10_my_reg   <= FW'(prody >> FRAC_BITS);
        g10_nx_reg   <= g9_neg_reg ^ sgnx;
        g10_ny_reg   <= g9_neg_reg ^ sgny;
        g10_kill_reg <= g9_kill_reg;

        // G11: saturate, or drop to zero on a separating axis
        result_reg.push_x <= g10_kill_reg ? '0 : sat_push(g10_nx_reg, g10_mx_reg);
        result_reg.push_y <= g10_kill_reg ? '0 : sat_push(g10_ny_reg, g10_my_reg);
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

>>> rtl/rrts_checker.sv
// Port-level checks for the resolver, bound to the top level.
// Depends on rrts_pkg for types and pipeline depth constants.
`timescale 1ns / 1ps
`default_nettype none

module rrts_checker
    import rrts_pkg::*;
#(
    parameter int FRAC_BITS = 16
)(
    input wire logic    clk,
    input wire logic    rst_n,
    input wire logic    start,
    input wire logic    busy,
    input wire query_t  query,
    input wire logic    done,
    input wire result_t result
);

    localparam int LATENCY = FRONT_STAGES + SQRT_STEPS + FRAC_BITS + 1 + GEO_STAGES;

    // Every transfer in produces a result after the fixed latency
    a_accept_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##LATENCY done)
        else $error("accepted query produced no result at the pipeline latency");

    // No result without a matching transfer in
    a_done_has_source: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, LATENCY))
        else $error("result strobe without a matching accepted query");

    // Degenerate shapes leave no overlap to resolve
    a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && ((query.tri_bx == 0 && query.tri_by == 0)
                            || query.rect_w == 0 || query.rect_h == 0))
        |-> ##LATENCY (result.push_x == 0 && result.push_y == 0))
        else $error("degenerate query gave a nonzero push");

    // The pipeline never holds off input once out of reset
    a_never_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy raised while running");

endmodule

bind rect_right_triangle_sat_resolve rrts_checker #(.FRAC_BITS(FRAC_BITS)) u_rrts_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .query  (query),
    .done   (done),
    .result (result)
);

`default_nettype wire
